// File: hdl/rebs_pkg.sv
// Shared types and constants for the record exchange sorter.
package rebs_pkg;

    localparam int KEY_W  = 32;
    localparam int TAG_W  = 16;
    localparam int DATA_W = 48;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [KEY_W-1:0] key;
    } t_rec;

    typedef struct packed {
        logic store;
        logic rd_i;
        logic hold;
        logic cmp;
        logic wb;
        logic out_rd;
        logic out_load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic j_end;
        logic i_end;
        logic k_end;
        logic out_busy;
    } t_stat;

endpackage

// File: hdl/rebs_dp.sv
// Datapath: record memory, sort counters, compare and swap, output register.
module rebs_dp #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rebs_pkg::t_cmd         i_cmd,
    input  rebs_pkg::t_rec         i_rec,
    input  logic                   i_out_ready,
    output rebs_pkg::t_stat        o_stat,
    output rebs_pkg::t_rec         o_rec,
    output logic                   o_last,
    output logic                   o_valid
);
    import rebs_pkg::*;

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

    t_rec            mem [MAX_RECORDS];
    t_rec            r_rd;
    t_rec            r_held;
    t_rec            r_out;
    logic            r_out_last;
    logic            r_out_valid;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   r_i;
    logic [AW-1:0]   r_j;
    logic [AW-1:0]   r_k;

    logic            full;
    logic            swap;
    logic            we;
    logic [AW-1:0]   wa;
    t_rec            wd;
    logic            re;
    logic [AW-1:0]   ra;

    assign full = (r_count == MAX_CNT);
    assign swap = (r_held.key > r_rd.key);

    always_comb begin
        we = 1'b0;
        wa = r_count[AW-1:0];
        wd = i_rec;
        if (i_cmd.store) begin
            we = !full;
        end else if (i_cmd.cmp) begin
            we = swap;
            wa = r_j;
            wd = r_held;
        end else if (i_cmd.wb) begin
            we = 1'b1;
            wa = r_i;
            wd = r_held;
        end
    end

    always_comb begin
        re = i_cmd.rd_i | i_cmd.hold | i_cmd.cmp | i_cmd.out_rd;
        ra = r_k;
        if (i_cmd.rd_i) begin
            ra = r_i;
        end else if (i_cmd.hold) begin
            ra = r_i + AW'(1);
        end else if (i_cmd.cmp) begin
            ra = r_j + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rd <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold) begin
            r_held <= r_rd;
        end else if (i_cmd.cmp && swap) begin
            r_held <= r_rd;
        end
        if (i_cmd.out_load) begin
            r_out      <= r_rd;
            r_out_last <= o_stat.k_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store && !full) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.hold) begin
                r_j <= r_i + AW'(1);
            end else if (i_cmd.cmp) begin
                r_j <= r_j + AW'(1);
            end
            if (i_cmd.wb) begin
                r_i <= r_i + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_k <= r_k + AW'(1);
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_i     <= '0;
                r_k     <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.j_end    = ((CW'(r_j) + CW'(1)) == r_count);
    assign o_stat.i_end    = ((CW'(r_i) + (CW+1)'(2)) >= {1'b0, r_count});
    assign o_stat.k_end    = ((CW'(r_k) + CW'(1)) == r_count);
    assign o_stat.out_busy = r_out_valid;

    assign o_rec   = r_out;
    assign o_last  = r_out_last;
    assign o_valid = r_out_valid;

endmodule

// File: hdl/rebs_ctrl.sv
// Controller: load, sort pass sequencing and ordered readout.
module rebs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    input  logic            i_out_ready,
    input  rebs_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output rebs_pkg::t_cmd  o_cmd
);
    import rebs_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RDI,
        S_HOLD,
        S_CMP,
        S_WB,
        S_ORD,
        S_OLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   out_free;

    assign o_in_ready = i_rst_n && (r_state == S_LOAD);
    assign in_acc     = o_in_ready && i_in_valid;
    assign out_free   = !i_stat.out_busy || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                o_cmd.store = in_acc;
                if (in_acc && i_in_last) begin
                    n_state = i_stat.empty ? S_ORD : S_RDI;
                end
            end
            S_RDI: begin
                o_cmd.rd_i = 1'b1;
                n_state    = S_HOLD;
            end
            S_HOLD: begin
                o_cmd.hold = 1'b1;
                n_state    = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_stat.j_end) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = i_stat.i_end ? S_ORD : S_RDI;
            end
            S_ORD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = S_OLD;
            end
            S_OLD: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.k_end) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/record_exchange_sort_by_key_top.sv
// Loading takes one word per cycle; the sort starts after the word marked by tlast.
// Sorting is an exchange sort: each outer pass holds record i, compares it with each
// later record, swapping on a greater held key, and writes the held record back to i;
// readout reads each word from the registered memory read port. Reset clears the
// record count and all control state; the record memory is not cleared.
module record_exchange_sort_by_key_top #(
    parameter int MAX_RECORDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key_value[31:0], record_tag[47:32]
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // sorted_key[31:0], sorted_tag[47:32]
    output logic        m_axis_tlast    // last_result
);
    import rebs_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_rec  in_rec;
    t_rec  out_rec;

    assign in_rec.key = s_axis_tdata[KEY_W-1:0];
    assign in_rec.tag = s_axis_tdata[DATA_W-1:KEY_W];

    rebs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (cmd)
    );

    rebs_dp #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rec       (in_rec),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_rec       (out_rec),
        .o_last      (m_axis_tlast),
        .o_valid     (m_axis_tvalid)
    );

    assign m_axis_tdata = {out_rec.tag, out_rec.key};

endmodule
